### hdl/shs_pkg.sv
// ----------------------------------------------------------------------------
// shs_pkg
// Types and codes shared by the source hunt sequencer modules.
// ----------------------------------------------------------------------------
package shs_pkg;

  // Command codes
  localparam logic [2:0] CMD_START      = 3'd0;
  localparam logic [2:0] CMD_ADVANCE    = 3'd1;
  localparam logic [2:0] CMD_FOUND_GOOD = 3'd2;
  localparam logic [2:0] CMD_ABORT_WIDE = 3'd3;
  localparam logic [2:0] CMD_ABORT      = 3'd4;
  localparam logic [2:0] CMD_CYCLE_VIEW = 3'd5;

  // Hunt kind codes (codes above KIND_NONE are held but start nothing)
  localparam logic [2:0] KIND_PUSH_IN         = 3'd0;
  localparam logic [2:0] KIND_PULL_OUT        = 3'd1;
  localparam logic [2:0] KIND_LONG_MARKERLESS = 3'd2;
  localparam logic [2:0] KIND_LONG_STABLE     = 3'd3;
  localparam logic [2:0] KIND_NONE            = 3'd4;

  // Configuration register indexes
  localparam logic [1:0] REG_SOURCE_COUNT      = 2'd0;
  localparam logic [1:0] REG_AUTO_SWITCH_EN    = 2'd1;
  localparam logic [1:0] REG_MARKERLESS_EN     = 2'd2;
  localparam logic [1:0] REG_MARKERLESS_INDEX  = 2'd3;

  localparam int unsigned CFG_DATA_W = 4;

  typedef struct packed {
    logic [2:0] cmd;
    logic [2:0] hunt_kind;
    logic       conclude_flag;
    logic [2:0] found_index;
    logic       markers_missing;
  } shs_in_t;

  typedef struct packed {
    logic [2:0] view_index;
    logic [2:0] track_index;
    logic       track_separate;
    logic       hunting;
    logic       advanced;
    logic       fade_request;
    logic [2:0] fade_from;
    logic       snap_request;
    logic       markerless_jump;
  } shs_out_t;

  typedef struct packed {
    logic [3:0] source_count;
    logic       auto_switch_enable;
    logic       markerless_enable;
    logic [2:0] markerless_index;
  } shs_cfg_t;

  function automatic logic kind_is_pull(input logic [2:0] kind);
    return (kind == KIND_PULL_OUT) || (kind == KIND_LONG_MARKERLESS);
  endfunction

endpackage

### hdl/source_hunt_sequencer_top.sv
// ----------------------------------------------------------------------------
// source_hunt_sequencer_top
// Camera hunt sequencer: push-in and pull-out hunts over ordered sources.
// ----------------------------------------------------------------------------
// One command transaction in gives one result transaction out. An accepted
// command waits in the input register until it can step; then the next-state
// logic of shs_core writes the hunt state and the output register at the
// same edge, and the result is presented from the output register.
// Commands stream at one per cycle; the only thing that slows the input
// side is a stalled output register that already holds a result while the
// input register is also full.
// Configuration registers are written through the cfg port (always ready)
// and are meant to change only when no command is in flight.
// ----------------------------------------------------------------------------
module source_hunt_sequencer_top #(
  parameter int unsigned MAX_SOURCES = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // command channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  shs_pkg::shs_in_t  in_data_i,
  // result channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output shs_pkg::shs_out_t out_data_o,
  // configuration write channel
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_index_i,
  input  logic [shs_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import shs_pkg::*;

  shs_cfg_t cfg_q;

  logic      in_vld_q;
  shs_in_t   in_item_q;
  logic      out_vld_q;
  shs_out_t  out_item_q;
  shs_out_t  result;
  logic      step;
  logic      in_take;

  // Configuration writes land at once; no back pressure on this port.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.source_count       <= 4'd1;
      cfg_q.auto_switch_enable <= 1'b0;
      cfg_q.markerless_enable  <= 1'b0;
      cfg_q.markerless_index   <= 3'd0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_SOURCE_COUNT:     cfg_q.source_count       <= cfg_data_i[3:0];
        REG_AUTO_SWITCH_EN:   cfg_q.auto_switch_enable <= cfg_data_i[0];
        REG_MARKERLESS_EN:    cfg_q.markerless_enable  <= cfg_data_i[0];
        REG_MARKERLESS_INDEX: cfg_q.markerless_index   <= cfg_data_i[2:0];
        default: begin
        end
      endcase
    end
  end

  // Advance the input register into the core whenever the output register
  // is empty or is being drained in this cycle.
  assign step       = in_vld_q && (!out_vld_q || !out_stall_i);
  // Hold off new transactions only when the input register cannot move.
  assign in_stall_o = in_vld_q && !step;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_take) begin
      in_vld_q <= 1'b1;
    end else if (step) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_item_q <= in_data_i;
    end
  end

  shs_core #(
    .MAX_SOURCES(MAX_SOURCES)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .item_i  (in_item_q),
    .cfg_i   (cfg_q),
    .result_o(result)
  );

  // Output register: load a fresh result on step, drop it once taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (step) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_item_q <= result;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_item_q;

endmodule

### hdl/shs_core.sv
// ----------------------------------------------------------------------------
// shs_core
// Hunt state registers and the per-command next-state and result logic.
// ----------------------------------------------------------------------------
module shs_core #(
  parameter int unsigned MAX_SOURCES = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  shs_pkg::shs_in_t  item_i,
  input  shs_pkg::shs_cfg_t cfg_i,
  output shs_pkg::shs_out_t result_o
);
  import shs_pkg::*;

  localparam int unsigned LOG_W = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
  localparam int unsigned IW    = (LOG_W > 3) ? LOG_W : 3;
  localparam int unsigned CW    = $clog2(MAX_SOURCES + 1);
  localparam int unsigned XW    = ((IW > CW) ? IW : CW) + 1;

  logic [IW-1:0] view_q, view_d;
  logic [IW-1:0] track_q, track_d;
  logic          hunt_q, hunt_d;
  logic [2:0]    kind_q, kind_d;
  logic [IW-1:0] probe_q, probe_d;
  logic [IW-1:0] stop_q, stop_d;
  logic          pull_q, pull_d;
  logic          concl_q, concl_d;

  logic [CW-1:0] count;
  logic [XW-1:0] count_x;
  logic [XW-1:0] view_inc;
  logic          do_push;
  logic          do_pull;
  logic          end_hunt;
  logic          advanced;
  logic          fade;
  logic          snap;
  logic          jump;

  // Clamp the source count to 1..MAX_SOURCES
  always_comb begin
    if (cfg_i.source_count == '0) begin
      count = CW'(1);
    end else if (int'(cfg_i.source_count) > int'(MAX_SOURCES)) begin
      count = CW'(MAX_SOURCES);
    end else begin
      count = CW'(cfg_i.source_count);
    end
  end

  assign count_x  = XW'(count);
  assign view_inc = XW'(view_q) + XW'(1);
  assign do_push  = (item_i.hunt_kind == KIND_PUSH_IN) ||
                    ((item_i.hunt_kind == KIND_LONG_STABLE) && !hunt_q);
  assign do_pull  = (item_i.hunt_kind == KIND_PULL_OUT) ||
                    ((item_i.hunt_kind == KIND_LONG_MARKERLESS) && !hunt_q);

  always_comb begin
    view_d   = view_q;
    track_d  = track_q;
    hunt_d   = hunt_q;
    kind_d   = kind_q;
    probe_d  = probe_q;
    stop_d   = stop_q;
    pull_d   = pull_q;
    concl_d  = concl_q;
    end_hunt = 1'b0;
    advanced = 1'b0;
    fade     = 1'b0;
    snap     = 1'b0;
    jump     = 1'b0;

    unique case (item_i.cmd)
      CMD_START: begin
        if (cfg_i.auto_switch_enable) begin
          kind_d  = item_i.hunt_kind;
          concl_d = item_i.conclude_flag;
          if (do_push) begin
            if (XW'(view_q) >= count_x - XW'(1)) begin
              end_hunt = 1'b1;
            end else begin
              stop_d  = view_q;
              hunt_d  = 1'b1;
              pull_d  = 1'b0;
              probe_d = IW'(count - CW'(1));
              track_d = IW'(count - CW'(1));
            end
          end else if (do_pull) begin
            if (view_q == '0) begin
              end_hunt = 1'b1;
            end else begin
              stop_d  = '0;
              hunt_d  = 1'b1;
              pull_d  = 1'b1;
              probe_d = view_q - IW'(1);
              track_d = view_q - IW'(1);
            end
          end
        end
      end
      CMD_ADVANCE: begin
        if (hunt_q) begin
          if (probe_q == '0) begin
            end_hunt = 1'b1;
          end else begin
            probe_d = probe_q - IW'(1);
            if ((XW'(probe_d) >= count_x) || (probe_d == stop_q)) begin
              end_hunt = 1'b1;
            end else begin
              track_d  = probe_d;
              advanced = 1'b1;
            end
          end
        end
      end
      CMD_FOUND_GOOD: begin
        fade   = kind_is_pull(kind_q) && (view_q != IW'(item_i.found_index));
        view_d = IW'(item_i.found_index);
        snap   = 1'b1;
        hunt_d = 1'b0;
        kind_d = KIND_NONE;
      end
      CMD_ABORT_WIDE: begin
        if (hunt_q && pull_q) begin
          hunt_d = 1'b0;
          kind_d = KIND_NONE;
        end
      end
      CMD_ABORT: begin
        hunt_d = 1'b0;
        kind_d = KIND_NONE;
      end
      CMD_CYCLE_VIEW: begin
        view_d = (view_inc >= count_x) ? '0 : IW'(view_inc);
      end
      default: begin
      end
    endcase

    // End of hunt: judge the markerless jump on the kind and flag now held
    if (end_hunt) begin
      jump   = kind_is_pull(kind_d) && item_i.markers_missing &&
               cfg_i.markerless_enable && concl_d;
      hunt_d = 1'b0;
      kind_d = KIND_NONE;
    end
  end

  always_comb begin
    result_o.view_index      = view_d[2:0];
    result_o.track_index     = track_d[2:0];
    result_o.track_separate  = hunt_d && (track_d != view_d);
    result_o.hunting         = hunt_d;
    result_o.advanced        = advanced;
    result_o.fade_request    = fade;
    result_o.fade_from       = view_q[2:0];
    result_o.snap_request    = snap;
    result_o.markerless_jump = jump;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      view_q  <= '0;
      track_q <= '0;
      hunt_q  <= 1'b0;
      kind_q  <= KIND_NONE;
      probe_q <= '0;
      stop_q  <= '0;
      pull_q  <= 1'b0;
      concl_q <= 1'b0;
    end else if (step_i) begin
      view_q  <= view_d;
      track_q <= track_d;
      hunt_q  <= hunt_d;
      kind_q  <= kind_d;
      probe_q <= probe_d;
      stop_q  <= stop_d;
      pull_q  <= pull_d;
      concl_q <= concl_d;
    end
  end

  // A pull-out hunt always runs down to the widest source
  a_pull_stops_at_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hunt_q && pull_q) |-> (stop_q == '0))
    else $error("pull-out hunt with nonzero stop index");

  a_fade_with_snap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && result_o.fade_request) |-> result_o.snap_request)
    else $error("fade without a found-good snap");

  a_advance_keeps_hunt : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && result_o.advanced) |=> hunt_q)
    else $error("advance left the hunt inactive");

  a_jump_ends_hunt : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && result_o.markerless_jump) |=> (!hunt_q && (kind_q == KIND_NONE)))
    else $error("markerless jump while a hunt is still active");

endmodule

### tb/tb_source_hunt_sequencer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_source_hunt_sequencer_top
// Self-checking bench for the source hunt sequencer top level.
// ----------------------------------------------------------------------------
// A queue of command transactions feeds a clocked driver. The driver runs
// its own copy of the hunt state on every accepted transaction and queues
// the result that the block must give. A clocked monitor checks each result
// transaction, field by field, against the oldest queued result. Both sides
// insert random idle cycles. The run moves through several register
// settings, each written while nothing is in flight.
// ----------------------------------------------------------------------------
module tb_source_hunt_sequencer_top;
  import shs_pkg::*;

  localparam int MAX_SRC = 8;
  localparam int RANDOM_CMDS = 1150;
  localparam int RANDOM_PHASES = 10;

  // Codes outside the defined sets; the block must ignore or merely hold them.
  localparam logic [2:0] CMD_RESERVED_LO = 3'd6;
  localparam logic [2:0] CMD_RESERVED_HI = 3'd7;
  localparam logic [2:0] KIND_RESERVED   = 3'd7;

  logic       clk_i;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  shs_in_t    in_data_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  shs_out_t   out_data_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [1:0] cfg_index_i = REG_SOURCE_COUNT;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  source_hunt_sequencer_top #(
    .MAX_SOURCES(MAX_SRC)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  // --------------------------------------------------------------------------
  // Shared bench state
  // --------------------------------------------------------------------------
  shs_in_t  pending_cmds[$];   // commands not yet presented to the block
  shs_out_t results_due[$];    // results predicted, oldest first
  int       mismatches = 0;
  int       send_gap_max = 0;  // upper bound of idle cycles between commands
  int       stall_max = 0;     // upper bound of stall cycles after a result

  // Register copies, updated only when the block is idle
  logic [3:0] set_count = 4'd1;
  logic       set_auto = 1'b0;
  logic       set_mless_en = 1'b0;
  logic [2:0] set_mless_idx = 3'd0;

  // Hunt state copy, same reset as the block
  logic [2:0] view_q = '0;
  logic [2:0] track_q = '0;
  logic       hunt_on = 1'b0;
  logic [2:0] held_kind = KIND_NONE;
  logic [3:0] probe_q = '0;
  logic [2:0] stop_q = '0;
  logic       pull_wide = 1'b0;
  logic       concl_q = 1'b0;

  // --------------------------------------------------------------------------
  // Clock and reset
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Hard stop: far beyond the slowest legal run (all gaps and stalls maximal).
  initial begin
    #10_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Hunt state predictor
  // --------------------------------------------------------------------------
  function automatic int active_sources();
    if (set_count == 4'd0) return 1;
    if (int'(set_count) > MAX_SRC) return MAX_SRC;
    return int'(set_count);
  endfunction

  function automatic logic held_is_pull();
    return (held_kind == KIND_PULL_OUT) || (held_kind == KIND_LONG_MARKERLESS);
  endfunction

  function automatic void drop_hunt();
    hunt_on = 1'b0;
    held_kind = KIND_NONE;
  endfunction

  // End a hunt; returns the markerless jump request.
  function automatic logic end_hunt(logic missing);
    logic jump;
    jump = held_is_pull() && missing && set_mless_en && concl_q;
    drop_hunt();
    return jump;
  endfunction

  function automatic logic open_push_in(logic missing);
    int n;
    n = active_sources();
    if (int'(view_q) >= n - 1) return end_hunt(missing);
    stop_q = view_q;
    hunt_on = 1'b1;
    pull_wide = 1'b0;
    probe_q = 4'(n - 1);
    track_q = probe_q[2:0];
    return 1'b0;
  endfunction

  function automatic logic open_pull_out(logic missing);
    if (view_q == 3'd0) return end_hunt(missing);
    stop_q = 3'd0;
    hunt_on = 1'b1;
    pull_wide = 1'b1;
    probe_q = {1'b0, view_q - 3'd1};
    track_q = probe_q[2:0];
    return 1'b0;
  endfunction

  // Apply one command to the state copy and return the result it must give.
  function automatic shs_out_t hunt_step(shs_in_t c);
    shs_out_t r;
    int n;
    int next_view;
    logic [2:0] prev_view;
    logic adv, fade, snap, jump;
    n = active_sources();
    prev_view = view_q;
    adv = 1'b0;
    fade = 1'b0;
    snap = 1'b0;
    jump = 1'b0;
    case (c.cmd)
      CMD_START: begin
        if (set_auto) begin
          held_kind = c.hunt_kind;
          concl_q = c.conclude_flag;
          if (c.hunt_kind == KIND_PUSH_IN ||
              (c.hunt_kind == KIND_LONG_STABLE && !hunt_on)) begin
            jump = open_push_in(c.markers_missing);
          end else if (c.hunt_kind == KIND_PULL_OUT ||
                       (c.hunt_kind == KIND_LONG_MARKERLESS && !hunt_on)) begin
            jump = open_pull_out(c.markers_missing);
          end
        end
      end
      CMD_ADVANCE: begin
        if (hunt_on) begin
          if (probe_q == 4'd0) begin
            jump = end_hunt(c.markers_missing);
          end else begin
            probe_q = probe_q - 4'd1;
            if (int'(probe_q) >= n || probe_q == {1'b0, stop_q}) begin
              jump = end_hunt(c.markers_missing);
            end else begin
              track_q = probe_q[2:0];
              adv = 1'b1;
            end
          end
        end
      end
      CMD_FOUND_GOOD: begin
        fade = held_is_pull() && (view_q != c.found_index);
        view_q = c.found_index;
        snap = 1'b1;
        drop_hunt();
      end
      CMD_ABORT_WIDE: begin
        if (hunt_on && pull_wide) drop_hunt();
      end
      CMD_ABORT: begin
        drop_hunt();
      end
      CMD_CYCLE_VIEW: begin
        next_view = int'(view_q) + 1;
        view_q = (next_view >= n) ? 3'd0 : 3'(next_view);
      end
      default: begin
      end
    endcase
    r.view_index      = view_q;
    r.track_index     = track_q;
    r.track_separate  = hunt_on && (track_q != view_q);
    r.hunting         = hunt_on;
    r.advanced        = adv;
    r.fade_request    = fade;
    r.fade_from       = prev_view;
    r.snap_request    = snap;
    r.markerless_jump = jump;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Helpers for idling and checking
  // --------------------------------------------------------------------------
  // Draw an idle count; at least a quarter of the draws give none, so bursts happen.
  function automatic int draw_idle(int max_idle);
    if (max_idle == 0 || $urandom_range(0, 3) == 0) return 0;
    return int'($urandom_range(0, max_idle));
  endfunction

  task automatic log_failure(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t ns: ERROR %s", $time, msg);
  endtask

  task automatic check_field(string name, logic [2:0] want, logic [2:0] got);
    if (want !== got)
      log_failure($sformatf("%s expected %0d actual %0d", name, want, got));
  endtask

  // --------------------------------------------------------------------------
  // Command driver: present queued commands, predict on every transaction
  // --------------------------------------------------------------------------
  int   gap_left = 0;
  logic drain_first = 1'b0;  // hold the next command until all results are in

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      gap_left = 0;
      drain_first = 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        results_due.push_back(hunt_step(in_data_i));
        gap_left = draw_idle(send_gap_max);
      end
      // Hold a stalled command as it is; otherwise pick what comes next.
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_cmds.size() != 0 &&
                     !(drain_first && results_due.size() != 0)) begin
          in_data_i <= pending_cmds.pop_front();
          in_valid_i <= 1'b1;
          drain_first = ($urandom_range(0, 59) == 0);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor: check each transaction, then stall for a random while
  // --------------------------------------------------------------------------
  int       stall_left = 0;
  shs_out_t want;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (results_due.size() == 0) begin
          log_failure($sformatf("result %h with nothing expected", out_data_o));
        end else begin
          want = results_due.pop_front();
          check_field("view_index", want.view_index, out_data_o.view_index);
          check_field("track_index", want.track_index, out_data_o.track_index);
          check_field("track_separate", want.track_separate,
                      out_data_o.track_separate);
          check_field("hunting", want.hunting, out_data_o.hunting);
          check_field("advanced", want.advanced, out_data_o.advanced);
          check_field("fade_request", want.fade_request, out_data_o.fade_request);
          check_field("fade_from", want.fade_from, out_data_o.fade_from);
          check_field("snap_request", want.snap_request, out_data_o.snap_request);
          check_field("markerless_jump", want.markerless_jump,
                      out_data_o.markerless_jump);
        end
        stall_left = draw_idle(stall_max);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  // Write all four registers back to back; valid stays high across them.
  task automatic apply_settings(logic [3:0] cnt, logic auto_en, logic mless_en,
                                logic [2:0] mless_idx);
    logic [1:0] idx[4];
    logic [3:0] val[4];
    idx = '{REG_SOURCE_COUNT, REG_AUTO_SWITCH_EN, REG_MARKERLESS_EN,
            REG_MARKERLESS_INDEX};
    val = '{cnt, {3'b0, auto_en}, {3'b0, mless_en}, {1'b0, mless_idx}};
    for (int i = 0; i < 4; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[i];
      cfg_data_i  <= val[i];
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    cfg_valid_i <= 1'b0;
    set_count = cnt;
    set_auto = auto_en;
    set_mless_en = mless_en;
    set_mless_idx = mless_idx;
  endtask

  // Wait until every command is in and every result is out, then let the
  // pipeline settle.
  task automatic wait_idle();
    while (pending_cmds.size() != 0 || results_due.size() != 0 || in_valid_i)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic shs_in_t make_cmd(logic [2:0] op, logic [2:0] kind,
                                       logic concl, logic [2:0] found,
                                       logic missing);
    shs_in_t c;
    c.cmd = op;
    c.hunt_kind = kind;
    c.conclude_flag = concl;
    c.found_index = found;
    c.markers_missing = missing;
    return c;
  endfunction

  function automatic shs_in_t rand_cmd();
    return make_cmd(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                    1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                    1'($urandom_range(0, 1)));
  endfunction

  // One hunt: a start, a run of advances with the odd restart or view cycle,
  // then a found, an abort or one more advance. Returns commands queued.
  function automatic int queue_hunt();
    shs_in_t c;
    int steps;
    c = rand_cmd();
    c.cmd = CMD_START;
    c.hunt_kind = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(4, 7))
                                              : 3'($urandom_range(0, 3));
    pending_cmds.push_back(c);
    steps = int'($urandom_range(0, 9));
    for (int i = 0; i < steps; i++) begin
      c = rand_cmd();
      case ($urandom_range(0, 11))
        0: c.cmd = CMD_CYCLE_VIEW;
        1: c.cmd = CMD_START;
        default: c.cmd = CMD_ADVANCE;
      endcase
      pending_cmds.push_back(c);
    end
    c = rand_cmd();
    case ($urandom_range(0, 4))
      0, 1: c.cmd = CMD_FOUND_GOOD;
      2: c.cmd = CMD_ABORT_WIDE;
      3: c.cmd = CMD_ABORT;
      default: c.cmd = CMD_ADVANCE;
    endcase
    pending_cmds.push_back(c);
    return steps + 2;
  endfunction

  initial begin
    logic [3:0] count_pick[5];
    logic [3:0] cnt;
    logic [2:0] mless_idx;
    shs_in_t c;
    int queued;
    int phase_quota;

    count_pick = '{4'd4, 4'd8, 4'd0, 4'd15, 4'd1};
    @(posedge rst_ni);
    @(posedge clk_i);

    // Directed walk through the hunt cases with four sources.
    apply_settings(4'd4, 1'b1, 1'b1, 3'd0);
    send_gap_max = 0;
    stall_max = 0;
    // Push-in from view 0 steps down to the stop index and ends.
    pending_cmds.push_back(make_cmd(CMD_START, KIND_PUSH_IN, 1'b0, 3'd0, 1'b0));
    repeat (3) pending_cmds.push_back(make_cmd(CMD_ADVANCE, KIND_NONE, 1'b0, 3'd0, 1'b1));
    // Advance with no hunt running does nothing.
    pending_cmds.push_back(make_cmd(CMD_ADVANCE, KIND_NONE, 1'b0, 3'd0, 1'b0));
    // Pull-out at view 0 has nothing to hunt: ends at once, jump raised.
    pending_cmds.push_back(make_cmd(CMD_START, KIND_PULL_OUT, 1'b1, 3'd0, 1'b1));
    repeat (3) pending_cmds.push_back(make_cmd(CMD_CYCLE_VIEW, KIND_NONE, 1'b0, 3'd0, 1'b0));
    // Push-in at the closest view has nothing to hunt; no jump for push-in.
    pending_cmds.push_back(make_cmd(CMD_START, KIND_PUSH_IN, 1'b1, 3'd0, 1'b1));
    pending_cmds.push_back(make_cmd(CMD_START, KIND_PULL_OUT, 1'b1, 3'd0, 1'b0));
    // Long kind during a hunt: held only, the hunt keeps going.
    pending_cmds.push_back(make_cmd(CMD_START, KIND_LONG_STABLE, 1'b0, 3'd0, 1'b0));
    pending_cmds.push_back(make_cmd(CMD_ADVANCE, KIND_NONE, 1'b0, 3'd0, 1'b0));
    // Found index beyond the count is taken as is; cycling it wraps to 0.
    pending_cmds.push_back(make_cmd(CMD_FOUND_GOOD, KIND_NONE, 1'b0, 3'd7, 1'b0));
    repeat (2) pending_cmds.push_back(make_cmd(CMD_CYCLE_VIEW, KIND_NONE, 1'b0, 3'd0, 1'b0));
    pending_cmds.push_back(make_cmd(CMD_START, KIND_LONG_MARKERLESS, 1'b1, 3'd0, 1'b0));
    pending_cmds.push_back(make_cmd(CMD_ABORT_WIDE, KIND_NONE, 1'b0, 3'd0, 1'b0));
    // Pull-out that fails with markers missing asks for the markerless jump.
    pending_cmds.push_back(make_cmd(CMD_START, KIND_PULL_OUT, 1'b1, 3'd0, 1'b0));
    pending_cmds.push_back(make_cmd(CMD_ADVANCE, KIND_NONE, 1'b0, 3'd0, 1'b1));
    // Unknown kind is held but starts nothing; unused commands do nothing.
    pending_cmds.push_back(make_cmd(CMD_START, KIND_RESERVED, 1'b1, 3'd0, 1'b1));
    pending_cmds.push_back(make_cmd(CMD_RESERVED_LO, KIND_NONE, 1'b1, 3'd7, 1'b1));
    pending_cmds.push_back(make_cmd(CMD_RESERVED_HI, KIND_RESERVED, 1'b0, 3'd5, 1'b0));
    // Abort-if-wide leaves a push-in running; found during push-in: no fade.
    pending_cmds.push_back(make_cmd(CMD_START, KIND_PUSH_IN, 1'b0, 3'd0, 1'b0));
    pending_cmds.push_back(make_cmd(CMD_ABORT_WIDE, KIND_NONE, 1'b0, 3'd0, 1'b0));
    pending_cmds.push_back(make_cmd(CMD_FOUND_GOOD, KIND_NONE, 1'b0, 3'd2, 1'b0));
    // Found during pull-out that changes the view asks for a fade.
    pending_cmds.push_back(make_cmd(CMD_START, KIND_PULL_OUT, 1'b0, 3'd0, 1'b0));
    pending_cmds.push_back(make_cmd(CMD_FOUND_GOOD, KIND_NONE, 1'b0, 3'd0, 1'b0));
    pending_cmds.push_back(make_cmd(CMD_ABORT, KIND_NONE, 1'b0, 3'd0, 1'b0));
    wait_idle();

    // Random phases: mostly well-formed hunts, a quarter loose commands.
    phase_quota = RANDOM_CMDS / RANDOM_PHASES;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      cnt = (p < 5) ? count_pick[p] : 4'($urandom_range(0, 15));
      mless_idx = (p == 0) ? 3'd7 : (p == 1) ? 3'd0 : 3'($urandom_range(0, 7));
      // Phase 3 runs with hunts disabled, so starts must be ignored.
      apply_settings(cnt, (p != 3), 1'((p + 1) % 3 != 0), mless_idx);
      send_gap_max = (p % 3 == 2) ? 0 : 18;
      stall_max = (p % 4 == 1) ? 0 : 18;
      queued = 0;
      while (queued < phase_quota) begin
        if ($urandom_range(0, 3) != 0) begin
          queued += queue_hunt();
        end else begin
          c = rand_cmd();
          pending_cmds.push_back(c);
          if (c.cmd <= CMD_CYCLE_VIEW) queued++;
        end
      end
      // Pressure: hold the rest of the phase until the block has drained.
      if (p == 4) begin
        wait_idle();
        repeat (10) pending_cmds.push_back(rand_cmd());
      end
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
